### sv/cos_pkg.sv
// ----------------------------------------------------------------------------
// cos_pkg
// Shared types and constants for the cursor overlay save-under block.
// ----------------------------------------------------------------------------
package cos_pkg;

  localparam int CURSOR_SIZE    = 16;
  localparam int MAX_SCREEN_DIM = 4096;
  localparam int CELLS          = CURSOR_SIZE * CURSOR_SIZE;
  localparam int CELL_W         = $clog2(CURSOR_SIZE);
  localparam int IDX_W          = $clog2(CELLS);
  localparam int COORD_W        = 12;
  localparam int DIM_W          = 13;
  localparam int PIX_W          = 32;
  localparam int MASK_W         = 64;
  localparam int MASK_REGS      = 4;
  localparam int Q_DEPTH        = 2;
  localparam int Q_PTR_W        = $clog2(Q_DEPTH);
  localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);
  localparam int ADDR_W         = 6;
  localparam int REG_IDX_W      = 3;

  localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_SCREEN_DIM);

  // opcodes
  localparam logic OP_DRAW  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // register indexes (byte address = 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_MASK0  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MASK1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MASK2  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MASK3  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COLOR  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd6;

  localparam logic [PIX_W-1:0] COLOR_RST  = 32'h00FF_FFFF;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd768;

  // classified cell, front to back
  typedef struct packed {
    logic               op;
    logic               active;
    logic               pass_end;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [PIX_W-1:0]   pix;
  } q_entry_t;

  // back end status
  typedef struct packed {
    logic drawn;
    logic busy;
  } cos_status_t;

endpackage

### sv/cos_front.sv
// ----------------------------------------------------------------------------
// cos_front
// Classifies an incoming cell: mask lookup, clipping and save-buffer index.
// ----------------------------------------------------------------------------
module cos_front (
  input  logic                                              in_opcode,
  input  logic [cos_pkg::COORD_W-1:0]                       in_cursor_x,
  input  logic [cos_pkg::COORD_W-1:0]                       in_cursor_y,
  input  logic [cos_pkg::CELL_W-1:0]                        in_cell_col,
  input  logic [cos_pkg::CELL_W-1:0]                        in_cell_row,
  input  logic [cos_pkg::PIX_W-1:0]                         in_pixel_now,
  input  logic                                              in_pass_end,
  input  logic [cos_pkg::MASK_REGS-1:0][cos_pkg::MASK_W-1:0] mask_rows,
  input  logic [cos_pkg::DIM_W-1:0]                         screen_width,
  input  logic [cos_pkg::DIM_W-1:0]                         screen_height,
  output cos_pkg::q_entry_t                                 entry
);

  logic [cos_pkg::MASK_W-1:0] mask_word;
  logic [5:0]                 bit_pos;
  logic                       mask_bit;
  logic [cos_pkg::DIM_W-1:0]  w_lim;
  logic [cos_pkg::DIM_W-1:0]  h_lim;
  logic [cos_pkg::DIM_W-1:0]  px_full;
  logic [cos_pkg::DIM_W-1:0]  py_full;

  // row 0 sits in the top bits, column 0 is the MSB of its row
  assign mask_word = mask_rows[in_cell_row[3:2]];
  assign bit_pos   = ~{in_cell_row[1:0], in_cell_col};
  assign mask_bit  = mask_word[bit_pos];

  assign w_lim = (screen_width  > cos_pkg::DIM_LIMIT) ? cos_pkg::DIM_LIMIT : screen_width;
  assign h_lim = (screen_height > cos_pkg::DIM_LIMIT) ? cos_pkg::DIM_LIMIT : screen_height;

  assign px_full = {1'b0, in_cursor_x} + cos_pkg::DIM_W'(in_cell_col);
  assign py_full = {1'b0, in_cursor_y} + cos_pkg::DIM_W'(in_cell_row);

  always_comb begin
    entry          = '0;
    entry.op       = in_opcode;
    entry.active   = mask_bit && (px_full < w_lim) && (py_full < h_lim);
    entry.pass_end = in_pass_end;
    entry.idx      = {in_cell_row, in_cell_col};
    entry.px       = px_full[cos_pkg::COORD_W-1:0];
    entry.py       = py_full[cos_pkg::COORD_W-1:0];
    entry.pix      = in_pixel_now;
  end

endmodule

### sv/cos_queue.sv
// ----------------------------------------------------------------------------
// cos_queue
// Short FIFO of classified cells between front and back.
// ----------------------------------------------------------------------------
module cos_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cos_pkg::q_entry_t push_data,
  input  logic              pop,
  output cos_pkg::q_entry_t pop_data,
  output logic              full,
  output logic              not_empty
);

  cos_pkg::q_entry_t                 slot_r [cos_pkg::Q_DEPTH];
  logic [cos_pkg::Q_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [cos_pkg::Q_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [cos_pkg::Q_CNT_W-1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == cos_pkg::Q_CNT_W'(cos_pkg::Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == cos_pkg::Q_PTR_W'(cos_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == cos_pkg::Q_PTR_W'(cos_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/cos_back.sv
// ----------------------------------------------------------------------------
// cos_back
// Save-under buffer access, restore compare and registered result word.
// ----------------------------------------------------------------------------
module cos_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  input  cos_pkg::q_entry_t             q_data,
  output logic                          q_pop,
  input  logic [cos_pkg::PIX_W-1:0]     cursor_color,
  output cos_pkg::cos_status_t          status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_write_enable,
  output logic [cos_pkg::COORD_W-1:0]   out_write_x,
  output logic [cos_pkg::COORD_W-1:0]   out_write_y,
  output logic [cos_pkg::PIX_W-1:0]     out_write_value
);

  // entry: {saved pixel, recorded value}
  logic [2*cos_pkg::PIX_W-1:0] mem [cos_pkg::CELLS];
  logic [cos_pkg::CELLS-1:0]   vld_r;
  logic [2*cos_pkg::PIX_W-1:0] rd_data_r;
  logic                        rd_hit_r;
  logic                        drawn_r;

  cos_pkg::q_entry_t           b2_item_r;
  logic                        b2_valid_r;
  logic                        b2_drawn_r;

  logic                        out_valid_r;
  logic                        out_we_r;
  logic [cos_pkg::COORD_W-1:0] out_x_r;
  logic [cos_pkg::COORD_W-1:0] out_y_r;
  logic [cos_pkg::PIX_W-1:0]   out_val_r;

  logic                        out_free;
  logic                        b2_go;
  logic                        mem_we;
  logic                        mem_re;
  logic [2*cos_pkg::PIX_W-1:0] rd_word;
  logic [cos_pkg::PIX_W-1:0]   saved_px;
  logic [cos_pkg::PIX_W-1:0]   over_px;
  logic                        res_we;
  logic [cos_pkg::PIX_W-1:0]   res_val;

  assign out_free = !out_valid_r || !out_stall;
  assign b2_go    = b2_valid_r && out_free;
  assign q_pop    = q_not_empty && (!b2_valid_r || b2_go);
  assign mem_we   = q_pop && (q_data.op == cos_pkg::OP_DRAW) && q_data.active;
  assign mem_re   = q_pop && (q_data.op == cos_pkg::OP_CLEAR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_data.idx] <= {q_data.pix, cursor_color};
    end
    if (mem_re) begin
      rd_data_r <= mem[q_data.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      drawn_r  <= 1'b0;
      rd_hit_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[q_data.idx] <= 1'b1;
      end
      if (mem_re) begin
        rd_hit_r <= vld_r[q_data.idx];
      end
      if (q_pop && (q_data.op == cos_pkg::OP_DRAW) && q_data.pass_end) begin
        drawn_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
    end else if (q_pop) begin
      b2_valid_r <= 1'b1;
    end else if (b2_go) begin
      b2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b2_item_r  <= q_data;
      b2_drawn_r <= drawn_r;
    end
  end

  // never-written entries read as zero
  assign rd_word  = rd_hit_r ? rd_data_r : '0;
  assign saved_px = rd_word[2*cos_pkg::PIX_W-1:cos_pkg::PIX_W];
  assign over_px  = rd_word[cos_pkg::PIX_W-1:0];

  always_comb begin
    unique case (b2_item_r.op)
      cos_pkg::OP_DRAW: begin
        res_we  = b2_item_r.active;
        res_val = cursor_color;
      end
      cos_pkg::OP_CLEAR: begin
        res_we  = b2_drawn_r && b2_item_r.active && (b2_item_r.pix == over_px);
        res_val = saved_px;
      end
      default: begin
        res_we  = 1'b0;
        res_val = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b2_go) begin
      out_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_go) begin
      out_we_r  <= res_we;
      out_x_r   <= res_we ? b2_item_r.px : '0;
      out_y_r   <= res_we ? b2_item_r.py : '0;
      out_val_r <= res_we ? res_val : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_write_x      = out_x_r;
  assign out_write_y      = out_y_r;
  assign out_write_value  = out_val_r;

  assign status.drawn = drawn_r;
  assign status.busy  = b2_valid_r || out_valid_r;

endmodule

### sv/cursor_overlay_save_under.sv
// ----------------------------------------------------------------------------
// cursor_overlay_save_under
// 16x16 one-bit cursor overlay with a save-under buffer.
// ----------------------------------------------------------------------------
// Takes one cursor cell per clock while in_stall is low and returns one
// pixel write word per cell, in order. An accepted cell is classified into
// a two-entry queue, then passes the save-buffer read stage and one output
// register. The only shared resource is the 256 x 64 save-under buffer,
// read or written at most once per cell, so the rate is one cell per cycle
// when nothing stalls. Buffer entries carry valid bits cleared by reset, so
// no clearing pass is needed and the block is ready right out of reset.
// Registers sit on a 64-bit APB port at byte address 8 * index.
module cursor_overlay_save_under (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cos_pkg::ADDR_W-1:0]    paddr,
  input  logic [cos_pkg::MASK_W-1:0]    pwdata,
  output logic [cos_pkg::MASK_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [cos_pkg::COORD_W-1:0]   in_cursor_x,
  input  logic [cos_pkg::COORD_W-1:0]   in_cursor_y,
  input  logic [cos_pkg::CELL_W-1:0]    in_cell_col,
  input  logic [cos_pkg::CELL_W-1:0]    in_cell_row,
  input  logic [cos_pkg::PIX_W-1:0]     in_pixel_now,
  input  logic                          in_pass_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_write_enable,
  output logic [cos_pkg::COORD_W-1:0]   out_write_x,
  output logic [cos_pkg::COORD_W-1:0]   out_write_y,
  output logic [cos_pkg::PIX_W-1:0]     out_write_value
);

  logic [cos_pkg::MASK_REGS-1:0][cos_pkg::MASK_W-1:0] mask_r;
  logic [cos_pkg::PIX_W-1:0]    color_r;
  logic [cos_pkg::DIM_W-1:0]    width_r;
  logic [cos_pkg::DIM_W-1:0]    height_r;
  logic                         cfg_wr;
  logic [cos_pkg::REG_IDX_W-1:0] reg_idx;

  cos_pkg::q_entry_t            fr_entry;
  cos_pkg::q_entry_t            q_data;
  logic                         q_full;
  logic                         q_not_empty;
  logic                         q_pop;
  logic                         in_take;
  cos_pkg::cos_status_t         bk_status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[cos_pkg::ADDR_W-1:cos_pkg::ADDR_W-cos_pkg::REG_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      color_r  <= cos_pkg::COLOR_RST;
      width_r  <= cos_pkg::WIDTH_RST;
      height_r <= cos_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        cos_pkg::REG_MASK0:  mask_r[0] <= pwdata;
        cos_pkg::REG_MASK1:  mask_r[1] <= pwdata;
        cos_pkg::REG_MASK2:  mask_r[2] <= pwdata;
        cos_pkg::REG_MASK3:  mask_r[3] <= pwdata;
        cos_pkg::REG_COLOR:  color_r   <= pwdata[cos_pkg::PIX_W-1:0];
        cos_pkg::REG_WIDTH:  width_r   <= pwdata[cos_pkg::DIM_W-1:0];
        cos_pkg::REG_HEIGHT: height_r  <= pwdata[cos_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cos_pkg::REG_MASK0:  prdata = mask_r[0];
      cos_pkg::REG_MASK1:  prdata = mask_r[1];
      cos_pkg::REG_MASK2:  prdata = mask_r[2];
      cos_pkg::REG_MASK3:  prdata = mask_r[3];
      cos_pkg::REG_COLOR:  prdata = cos_pkg::MASK_W'(color_r);
      cos_pkg::REG_WIDTH:  prdata = cos_pkg::MASK_W'(width_r);
      cos_pkg::REG_HEIGHT: prdata = cos_pkg::MASK_W'(height_r);
      default:             prdata = '0;
    endcase
  end

  assign in_stall = q_full;
  assign in_take  = in_valid && !in_stall;

  cos_front u_front (
    .in_opcode     (in_opcode),
    .in_cursor_x   (in_cursor_x),
    .in_cursor_y   (in_cursor_y),
    .in_cell_col   (in_cell_col),
    .in_cell_row   (in_cell_row),
    .in_pixel_now  (in_pixel_now),
    .in_pass_end   (in_pass_end),
    .mask_rows     (mask_r),
    .screen_width  (width_r),
    .screen_height (height_r),
    .entry         (fr_entry)
  );

  cos_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (fr_entry),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  cos_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .cursor_color     (color_r),
    .status           (bk_status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_enable (out_write_enable),
    .out_write_x      (out_write_x),
    .out_write_y      (out_write_y),
    .out_write_value  (out_write_value)
  );

  // a word without a write carries all-zero fields
  a_idle_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |->
      (out_write_x == '0) && (out_write_y == '0) && (out_write_value == '0))
    else $error("write-less word has nonzero fields");

  // the drawn flag is never cleared outside reset
  a_drawn_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(bk_status.drawn) |-> bk_status.drawn)
    else $error("drawn flag cleared");

  // output only follows back-end work; q_pop itself requires a non-empty queue
  a_out_from_back: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_status.busy))
    else $error("output word without back-end item");

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cursor overlay save-under block.
// ----------------------------------------------------------------------------
// Drives cursor cells of draw and clear passes over the in_ channel and
// compares every pixel write word on the out_ channel against a local
// predictor that keeps its own save-under and written-over buffers, drawn
// flag and register copies. Registers are loaded over APB between phases,
// only while the block is drained. Directed tests cover reset geometry,
// clear before any draw, restore and mismatch, draw/clear on the same cell
// back to back, zero and saturated screen sizes and an empty mask. Random
// phases then run well-formed draw/clear pass pairs near and away from the
// clip edges, mixed with noise cells, under random idle and stall bursts.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic                        op;
    logic [cos_pkg::COORD_W-1:0] cx;
    logic [cos_pkg::COORD_W-1:0] cy;
    logic [cos_pkg::CELL_W-1:0]  col;
    logic [cos_pkg::CELL_W-1:0]  row;
    logic [cos_pkg::PIX_W-1:0]   pix;
    logic                        last;
  } cell_t;

  typedef struct packed {
    logic                        we;
    logic [cos_pkg::COORD_W-1:0] x;
    logic [cos_pkg::COORD_W-1:0] y;
    logic [cos_pkg::PIX_W-1:0]   value;
  } pix_write_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [cos_pkg::ADDR_W-1:0]   paddr = '0;
  logic [cos_pkg::MASK_W-1:0]   pwdata = '0;
  logic [cos_pkg::MASK_W-1:0]   prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_opcode = cos_pkg::OP_DRAW;
  logic [cos_pkg::COORD_W-1:0]  in_cursor_x = '0;
  logic [cos_pkg::COORD_W-1:0]  in_cursor_y = '0;
  logic [cos_pkg::CELL_W-1:0]   in_cell_col = '0;
  logic [cos_pkg::CELL_W-1:0]   in_cell_row = '0;
  logic [cos_pkg::PIX_W-1:0]    in_pixel_now = '0;
  logic                         in_pass_end = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_write_enable;
  logic [cos_pkg::COORD_W-1:0]  out_write_x;
  logic [cos_pkg::COORD_W-1:0]  out_write_y;
  logic [cos_pkg::PIX_W-1:0]    out_write_value;

  // predictor state
  logic [cos_pkg::MASK_W-1:0] mask_q [cos_pkg::MASK_REGS] = '{default: '0};
  logic [cos_pkg::PIX_W-1:0]  color_q = cos_pkg::COLOR_RST;
  logic [cos_pkg::DIM_W-1:0]  width_q = cos_pkg::WIDTH_RST;
  logic [cos_pkg::DIM_W-1:0]  height_q = cos_pkg::HEIGHT_RST;
  logic [cos_pkg::PIX_W-1:0]  saved_q [cos_pkg::CELLS] = '{default: '0};
  logic [cos_pkg::PIX_W-1:0]  over_q [cos_pkg::CELLS] = '{default: '0};
  logic                       drawn_q = 1'b0;

  pix_write_t pending_writes [$];
  int         mismatches = 0;
  int         sent_count = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;

  cursor_overlay_save_under dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_cursor_x      (in_cursor_x),
    .in_cursor_y      (in_cursor_y),
    .in_cell_col      (in_cell_col),
    .in_cell_row      (in_cell_row),
    .in_pixel_now     (in_pixel_now),
    .in_pass_end      (in_pass_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_enable (out_write_enable),
    .out_write_x      (out_write_x),
    .out_write_y      (out_write_y),
    .out_write_value  (out_write_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] dim_clamp(input logic [cos_pkg::DIM_W-1:0] d);
    return (d > cos_pkg::DIM_LIMIT) ? 32'(cos_pkg::DIM_LIMIT) : 32'(d);
  endfunction

  function automatic cell_t mk_cell(input logic op,
                                    input logic [cos_pkg::COORD_W-1:0] cx,
                                    input logic [cos_pkg::COORD_W-1:0] cy,
                                    input logic [cos_pkg::CELL_W-1:0] col,
                                    input logic [cos_pkg::CELL_W-1:0] row,
                                    input logic [cos_pkg::PIX_W-1:0] pix,
                                    input logic last);
    cell_t c;
    c = '{op, cx, cy, col, row, pix, last};
    return c;
  endfunction

  function automatic pix_write_t predict_write(input cell_t c);
    logic [31:0] px;
    logic [31:0] py;
    logic [cos_pkg::IDX_W-1:0] idx;
    logic [5:0] pos;
    logic hit;
    pix_write_t w;
    px = 32'(c.cx) + 32'(c.col);
    py = 32'(c.cy) + 32'(c.row);
    idx = {c.row, c.col};
    pos = {c.row[1:0], c.col};
    hit = mask_q[c.row[3:2]][63 - pos] && (px < dim_clamp(width_q)) &&
          (py < dim_clamp(height_q));
    w = '0;
    if (c.op == cos_pkg::OP_DRAW) begin
      if (hit) begin
        saved_q[idx] = c.pix;
        over_q[idx] = color_q;
        w = '{1'b1, px[cos_pkg::COORD_W-1:0], py[cos_pkg::COORD_W-1:0], color_q};
      end
      if (c.last) drawn_q = 1'b1;
    end else if (drawn_q && hit && (c.pix == over_q[idx])) begin
      w = '{1'b1, px[cos_pkg::COORD_W-1:0], py[cos_pkg::COORD_W-1:0], saved_q[idx]};
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  task automatic write_reg(input logic [cos_pkg::REG_IDX_W-1:0] idx,
                           input logic [cos_pkg::MASK_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      cos_pkg::REG_MASK0, cos_pkg::REG_MASK1, cos_pkg::REG_MASK2, cos_pkg::REG_MASK3:
        mask_q[idx[1:0]] = value;
      cos_pkg::REG_COLOR: color_q = value[cos_pkg::PIX_W-1:0];
      cos_pkg::REG_WIDTH: width_q = value[cos_pkg::DIM_W-1:0];
      cos_pkg::REG_HEIGHT: height_q = value[cos_pkg::DIM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_cell(input cell_t c);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= c.op;
    in_cursor_x <= c.cx;
    in_cursor_y <= c.cy;
    in_cell_col <= c.col;
    in_cell_row <= c.row;
    in_pixel_now <= c.pix;
    in_pass_end <= c.last;
    do @(posedge clk); while (in_stall);
    pending_writes.push_back(predict_write(c));
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_clear_before_draw();
    write_reg(cos_pkg::REG_MASK0, '1);
    write_reg(cos_pkg::REG_MASK1, '1);
    write_reg(cos_pkg::REG_MASK2, '1);
    write_reg(cos_pkg::REG_MASK3, '1);
    send_cell(mk_cell(cos_pkg::OP_CLEAR, 12'd0, 12'd0, 4'd0, 4'd0, 32'd0, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_CLEAR, 12'd10, 12'd10, 4'd3, 4'd4, 32'd0, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_CLEAR, 12'd10, 12'd10, 4'd3, 4'd4, cos_pkg::COLOR_RST,
                      1'b1));
  endtask

  task automatic test_reset_geometry();
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd1020, 12'd10, 4'd3, 4'd0, 32'hA5A5_0001, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd1020, 12'd10, 4'd4, 4'd0, 32'hA5A5_0002, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd0, 12'd760, 4'd0, 4'd7, 32'hA5A5_0003, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd0, 12'd760, 4'd0, 4'd8, 32'hA5A5_0004, 1'b0));
    drain();
  endtask

  task automatic test_draw_then_clear();
    write_reg(cos_pkg::REG_COLOR, 64'hFFFF_0000_1234_5678);
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd100, 12'd200, 4'd0, 4'd0, 32'h0000_0011, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd100, 12'd200, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd100, 12'd200, 4'd7, 4'd5, 32'h8000_0000, 1'b1));
    send_cell(mk_cell(cos_pkg::OP_CLEAR, 12'd100, 12'd200, 4'd0, 4'd0, color_q, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_CLEAR, 12'd100, 12'd200, 4'd15, 4'd15, ~color_q, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_CLEAR, 12'd100, 12'd200, 4'd7, 4'd5, color_q, 1'b1));
    // same cell drawn and cleared back to back
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd300, 12'd40, 4'd3, 4'd3, 32'h5555_AAAA, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_CLEAR, 12'd300, 12'd40, 4'd3, 4'd3, color_q, 1'b0));
    drain();
  endtask

  task automatic test_clip_extremes();
    write_reg(cos_pkg::REG_WIDTH, 64'd0);
    write_reg(cos_pkg::REG_HEIGHT, 64'd0);
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd0, 12'd0, 4'd0, 4'd0, 32'h1, 1'b1));
    drain();
    write_reg(cos_pkg::REG_WIDTH, 64'd8191);
    write_reg(cos_pkg::REG_HEIGHT, 64'd8191);
    write_reg(cos_pkg::REG_COLOR, 64'd0);
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'hFFF, 12'hFFF, 4'd0, 4'd0, 32'h2, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'hFFF, 12'hFFF, 4'd1, 4'd0, 32'h3, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'hFFF, 12'hFFF, 4'd0, 4'd1, 32'h4, 1'b1));
    drain();
    write_reg(cos_pkg::REG_WIDTH, 64'd1);
    write_reg(cos_pkg::REG_HEIGHT, 64'd1);
    write_reg(cos_pkg::REG_COLOR, 64'hFFFF_FFFF);
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd0, 12'd0, 4'd0, 4'd0, 32'h5, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd0, 12'd0, 4'd1, 4'd0, 32'h6, 1'b1));
    drain();
    write_reg(cos_pkg::REG_MASK0, 64'd0);
    send_cell(mk_cell(cos_pkg::OP_DRAW, 12'd0, 12'd0, 4'd0, 4'd0, 32'h7, 1'b0));
    send_cell(mk_cell(cos_pkg::OP_CLEAR, 12'd0, 12'd0, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b0));
    drain();
  endtask

  task automatic test_random_passes(input int phases, input int per_phase);
    logic [cos_pkg::MASK_W-1:0]  m [cos_pkg::MASK_REGS];
    logic [cos_pkg::MASK_W-1:0]  junk;
    logic [cos_pkg::PIX_W-1:0]   colr;
    logic [cos_pkg::DIM_W-1:0]   w;
    logic [cos_pkg::DIM_W-1:0]   h;
    logic [cos_pkg::COORD_W-1:0] cx;
    logic [cos_pkg::COORD_W-1:0] cy;
    logic [cos_pkg::IDX_W-1:0]   idx;
    logic [cos_pkg::IDX_W-1:0]   cells [$];
    logic [cos_pkg::PIX_W-1:0]   pix;
    logic [95:0]                 rnd;
    int start;
    int n;
    bit fwd;
    for (int p = 0; p < phases; p++) begin
      if (p == phases - 1) calm = 1'b1;
      for (int k = 0; k < cos_pkg::MASK_REGS; k++) begin
        m[k] = {$urandom, $urandom};
        case ($urandom_range(0, 2))
          1: m[k] = m[k] | {$urandom, $urandom};
          2: m[k] = m[k] & {$urandom, $urandom};
          default: ;
        endcase
      end
      colr = $urandom;
      if ($urandom_range(0, 4) == 0) w = 13'($urandom_range(4097, 8191));
      else w = 13'($urandom_range(1, 4096));
      if ($urandom_range(0, 4) == 0) h = 13'($urandom_range(4097, 8191));
      else h = 13'($urandom_range(1, 4096));
      if (p == 0) begin
        m = '{default: '1};
        colr = '0;
        w = 13'd4096;
        h = 13'd4096;
      end else if (p == 1) begin
        colr = '1;
        w = 13'd8191;
        h = 13'd8191;
      end else if (p == 2) begin
        w = 13'($urandom_range(1, 40));
        h = 13'($urandom_range(1, 40));
      end
      write_reg(cos_pkg::REG_MASK0, m[0]);
      write_reg(cos_pkg::REG_MASK1, m[1]);
      write_reg(cos_pkg::REG_MASK2, m[2]);
      write_reg(cos_pkg::REG_MASK3, m[3]);
      junk = {$urandom, $urandom};
      write_reg(cos_pkg::REG_COLOR, {junk[63:32], colr});
      junk = {$urandom, $urandom};
      write_reg(cos_pkg::REG_WIDTH, {junk[63:13], w});
      junk = {$urandom, $urandom};
      write_reg(cos_pkg::REG_HEIGHT, {junk[63:13], h});
      start = sent_count;
      while (sent_count - start < per_phase) begin
        if ($urandom_range(0, 9) == 0) begin
          rnd = {$urandom, $urandom, $urandom};
          send_cell(cell_t'(rnd[$bits(cell_t)-1:0]));
        end else begin
          cx = 12'($urandom);
          cy = 12'($urandom);
          if ($urandom_range(0, 1)) cx = 12'(dim_clamp(width_q) - $urandom_range(0, 16));
          if ($urandom_range(0, 1)) cy = 12'(dim_clamp(height_q) - $urandom_range(0, 16));
          n = $urandom_range(1, 20);
          cells.delete();
          for (int i = 0; i < n; i++) begin
            idx = 8'($urandom);
            cells.push_back(idx);
            send_cell(mk_cell(cos_pkg::OP_DRAW, cx, cy, idx[3:0], idx[7:4], $urandom,
                              (i == n - 1) || ($urandom_range(0, 15) == 0)));
          end
          fwd = 1'($urandom_range(0, 1));
          for (int i = 0; i < n; i++) begin
            idx = fwd ? cells[i] : cells[n - 1 - i];
            pix = ($urandom_range(0, 9) < 7) ? over_q[idx] : $urandom;
            send_cell(mk_cell(cos_pkg::OP_CLEAR, cx, cy, idx[3:0], idx[7:4], pix,
                              (i == n - 1) && $urandom_range(0, 1)));
          end
        end
      end
      drain();
    end
  endtask

  initial begin
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pix_write_t want_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected word", out_write_value, '0);
      end else begin
        want_w = pending_writes.pop_front();
        if (out_write_enable !== want_w.we)
          report_mismatch("write_enable", 32'(out_write_enable), 32'(want_w.we));
        if (out_write_x !== want_w.x)
          report_mismatch("write_x", 32'(out_write_x), 32'(want_w.x));
        if (out_write_y !== want_w.y)
          report_mismatch("write_y", 32'(out_write_y), 32'(want_w.y));
        if (out_write_value !== want_w.value)
          report_mismatch("write_value", out_write_value, want_w.value);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_clear_before_draw();
    test_reset_geometry();
    test_draw_then_clear();
    test_clip_extremes();
    test_random_passes(10, 100);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### cursor_overlay_save_under.f
sv/cos_pkg.sv
sv/cos_front.sv
sv/cos_queue.sv
sv/cos_back.sv
sv/cursor_overlay_save_under.sv
sim/tb.sv
